/* design/rcm_pkg.sv */
// Shared types and codes for the character RSA modular exponentiation block.
`default_nettype none

package rcm_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    // Register index, taken from byte address bits [3:2].
    typedef enum logic [1:0] {
        REG_PUBLIC_EXP  = 2'd0,
        REG_PRIVATE_EXP = 2'd1,
        REG_MODULUS     = 2'd2,
        REG_CHAR_OFFSET = 2'd3
    } reg_idx_t;

    // Operation codes of an input item.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam int unsigned CFG_ADDR_BITS = 4;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned OFFSET_BITS   = 8;

endpackage

`default_nettype wire

/* design/rsa_char_modexp.sv */
// Top level: bit-serial modular exponentiation for per-character RSA.
`default_nettype none

// Each item is one modular exponentiation done with a single shared modular
// multiplier that consumes one multiplier bit per cycle (double, conditionally
// add, reduce), so one modular product consumes MUL_BITS = max(MOD_BITS, 32)
// multiplier bits. An item first reduces its base modulo n (one product), then
// runs left-to-right square-and-multiply over EXP_BITS exponent bits: one
// square per bit plus one multiply per set bit. A zero modulus skips all
// products. One item is worked on at a time; a new item is taken while the
// previous result still waits in the output register. Encrypt uses the low 8
// bits of the value plus char_offset as the message; decrypt returns the low
// byte of the plaintext minus char_offset, zero-extended. The modulus is taken
// to MOD_BITS bits and the exponents to EXP_BITS bits.
module rsa_char_modexp #(
    parameter int unsigned MOD_BITS = 32,
    parameter int unsigned EXP_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [31:0] s_value,
    // Result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_result
);

    localparam int unsigned W        = MOD_BITS;
    localparam int unsigned MUL_BITS = (MOD_BITS > 32) ? MOD_BITS : 32;
    localparam int unsigned MCW      = $clog2(MUL_BITS + 1);
    localparam int unsigned ECW      = $clog2(EXP_BITS + 1);

    // Configuration registers
    logic [31:0] public_exponent_reg;
    logic [31:0] private_exponent_reg;
    logic [31:0] modulus_reg;
    logic [7:0]  char_offset_reg;
    logic        cfg_write;

    // Sequencer and datapath registers
    rcm_pkg::state_t      state_reg, state_next;
    logic                 op_reg, op_next;
    logic [W-1:0]         n_reg, n_next;
    logic [W:0]           n2_reg, n2_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         base_reg, base_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         r_reg, r_next;
    logic [MUL_BITS-1:0]  mul_sh_reg, mul_sh_next;
    logic [MCW-1:0]       mcnt_reg, mcnt_next;
    logic [EXP_BITS-1:0]  exp_reg, exp_next;
    logic [ECW-1:0]       ecnt_reg, ecnt_next;
    logic [31:0]          result_reg, result_next;
    logic                 m_valid_reg, m_valid_next;

    // Datapath signals
    logic [W-1:0]         addend;
    logic [W+1:0]         t_sum;
    logic [W+1:0]         t_sub1;
    logic [W+1:0]         t_sub2;
    logic [W-1:0]         red;
    logic                 mul_last;
    logic                 exp_last;
    logic [63:0]          n_wide;
    logic [W-1:0]         n_in;
    logic [W-1:0]         one_in;
    logic [W-1:0]         one_n;
    logic [63:0]          exp_wide;
    logic [8:0]           m_enc;
    logic [63:0]          base_wide;
    logic [63:0]          r_wide;
    logic [7:0]           r_byte;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            public_exponent_reg  <= 32'd1;
            private_exponent_reg <= 32'd1;
            modulus_reg          <= 32'd100;
            char_offset_reg      <= 8'd0;
        end else if (cfg_write) begin
            unique case (rcm_pkg::reg_idx_t'(paddr[3:2]))
                rcm_pkg::REG_PUBLIC_EXP:  public_exponent_reg  <= pwdata;
                rcm_pkg::REG_PRIVATE_EXP: private_exponent_reg <= pwdata;
                rcm_pkg::REG_MODULUS:     modulus_reg          <= pwdata;
                rcm_pkg::REG_CHAR_OFFSET: char_offset_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rcm_pkg::reg_idx_t'(paddr[3:2]))
            rcm_pkg::REG_PUBLIC_EXP:  prdata = public_exponent_reg;
            rcm_pkg::REG_PRIVATE_EXP: prdata = private_exponent_reg;
            rcm_pkg::REG_MODULUS:     prdata = modulus_reg;
            rcm_pkg::REG_CHAR_OFFSET: prdata = {24'd0, char_offset_reg};
            default:                  prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Bit-serial modular multiplier step: acc = (2*acc + bit*a) mod n.
    // Both acc and a stay below n, so the sum is below 3n and one of
    // t, t-n, t-2n is the reduced value.
    //------------------------------------------------------------------
    assign addend   = mul_sh_reg[MUL_BITS-1] ? a_reg : '0;
    assign t_sum    = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
    assign t_sub1   = t_sum - {2'b00, n_reg};
    assign t_sub2   = t_sum - {1'b0, n2_reg};
    assign mul_last = (mcnt_reg == MCW'(1));
    assign exp_last = (ecnt_reg == ECW'(1));

    always_comb begin
        if (t_sum >= {1'b0, n2_reg}) begin
            red = t_sub2[W-1:0];
        end else if (t_sum >= {2'b00, n_reg}) begin
            red = t_sub1[W-1:0];
        end else begin
            red = t_sum[W-1:0];
        end
    end

    // Operand preparation for a new item.
    assign n_wide    = 64'(modulus_reg);
    assign n_in      = n_wide[W-1:0];
    assign one_in    = (n_in == W'(1)) ? '0 : W'(1);
    assign one_n     = (n_reg == W'(1)) ? '0 : W'(1);
    assign exp_wide  = (s_operation == rcm_pkg::OP_DECRYPT) ? 64'(private_exponent_reg)
                                                            : 64'(public_exponent_reg);
    assign m_enc     = {1'b0, s_value[7:0]} + {1'b0, char_offset_reg};
    assign base_wide = (s_operation == rcm_pkg::OP_DECRYPT) ? 64'(s_value) : 64'(m_enc);
    assign r_wide    = 64'(r_reg);
    assign r_byte    = r_reg[7:0] - char_offset_reg;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rcm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        n_reg      <= n_next;
        n2_reg     <= n2_next;
        a_reg      <= a_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        r_reg      <= r_next;
        mul_sh_reg <= mul_sh_next;
        mcnt_reg   <= mcnt_next;
        exp_reg    <= exp_next;
        ecnt_reg   <= ecnt_next;
        result_reg <= result_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        n_next       = n_reg;
        n2_next      = n2_reg;
        a_next       = a_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        r_next       = r_reg;
        mul_sh_next  = mul_sh_reg;
        mcnt_next    = mcnt_reg;
        exp_next     = exp_reg;
        ecnt_next    = ecnt_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        unique case (state_reg)
            rcm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next   = s_operation;
                    n_next    = n_in;
                    n2_next   = {n_in, 1'b0};
                    exp_next  = exp_wide[EXP_BITS-1:0];
                    ecnt_next = ECW'(EXP_BITS);
                    acc_next  = '0;
                    if (n_in == '0) begin
                        // A zero modulus gives a plaintext or cipher of zero.
                        r_next     = '0;
                        state_next = rcm_pkg::ST_FINISH;
                    end else begin
                        // Base reduction: base * (1 mod n), fed base-first.
                        a_next      = one_in;
                        mul_sh_next = base_wide[MUL_BITS-1:0];
                        mcnt_next   = MCW'(MUL_BITS);
                        state_next  = rcm_pkg::ST_REDUCE;
                    end
                end
            end

            rcm_pkg::ST_REDUCE: begin
                acc_next    = red;
                mul_sh_next = {mul_sh_reg[MUL_BITS-2:0], 1'b0};
                mcnt_next   = mcnt_reg - MCW'(1);
                if (mul_last) begin
                    base_next   = red;
                    r_next      = one_n;
                    acc_next    = '0;
                    a_next      = one_n;
                    mul_sh_next = MUL_BITS'(one_n);
                    mcnt_next   = MCW'(MUL_BITS);
                    state_next  = rcm_pkg::ST_SQUARE;
                end
            end

            rcm_pkg::ST_SQUARE: begin
                acc_next    = red;
                mul_sh_next = {mul_sh_reg[MUL_BITS-2:0], 1'b0};
                mcnt_next   = mcnt_reg - MCW'(1);
                if (mul_last) begin
                    r_next      = red;
                    acc_next    = '0;
                    mcnt_next   = MCW'(MUL_BITS);
                    mul_sh_next = MUL_BITS'(red);
                    if (exp_reg[EXP_BITS-1]) begin
                        a_next     = base_reg;
                        state_next = rcm_pkg::ST_MULT;
                    end else begin
                        exp_next  = {exp_reg[EXP_BITS-2:0], 1'b0};
                        ecnt_next = ecnt_reg - ECW'(1);
                        a_next    = red;
                        if (exp_last) begin
                            state_next = rcm_pkg::ST_FINISH;
                        end
                    end
                end
            end

            rcm_pkg::ST_MULT: begin
                acc_next    = red;
                mul_sh_next = {mul_sh_reg[MUL_BITS-2:0], 1'b0};
                mcnt_next   = mcnt_reg - MCW'(1);
                if (mul_last) begin
                    r_next      = red;
                    acc_next    = '0;
                    mcnt_next   = MCW'(MUL_BITS);
                    mul_sh_next = MUL_BITS'(red);
                    a_next      = red;
                    exp_next    = {exp_reg[EXP_BITS-2:0], 1'b0};
                    ecnt_next   = ecnt_reg - ECW'(1);
                    if (exp_last) begin
                        state_next = rcm_pkg::ST_FINISH;
                    end else begin
                        state_next = rcm_pkg::ST_SQUARE;
                    end
                end
            end

            rcm_pkg::ST_FINISH: begin
                // Wait until the output register is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    if (op_reg == rcm_pkg::OP_DECRYPT) begin
                        result_next = {24'd0, r_byte};
                    end else begin
                        result_next = r_wide[31:0];
                    end
                    m_valid_next = 1'b1;
                    state_next   = rcm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rcm_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

/* design/rcm_checker.sv */
// Port-level checks for the character RSA block, bound to its top level.
`default_nettype none

module rcm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_result
);

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result item dropped or changed while stalled");

    // The block works on one item at a time, so it is busy right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in work");

    // Reset leaves the block ready and with no pending result.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // A modulus write reads back on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr[3:2] == rcm_pkg::REG_MODULUS)
        |=> (paddr[3:2] != rcm_pkg::REG_MODULUS) || (prdata == $past(pwdata)))
        else $error("modulus register does not read back the written value");

endmodule

bind rsa_char_modexp rcm_checker u_rcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

`default_nettype wire

/* tb/tb_rsa_char_modexp.sv */
// Self-checking testbench for the character RSA modular exponentiation block.
`default_nettype none

module tb_rsa_char_modexp;

    localparam int unsigned STALL_LIMIT  = 40000;
    localparam int unsigned ITEM_CYCLES  = 2100;
    localparam int unsigned LONG_HOLDOFF = 6000;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result;

    // Key material as the block should currently hold it.
    logic [31:0] pub_exp_q  = 32'd1;
    logic [31:0] priv_exp_q = 32'd1;
    logic [31:0] modulus_q  = 32'd100;
    logic [7:0]  offset_q   = 8'd0;

    logic [31:0] pending_results[$];
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_hold    = 0;
    int unsigned sink_gap     = 0;
    bit          idle_on      = 1'b1;

    rsa_char_modexp u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [31:0] mod_power(input logic [31:0] base, input logic [31:0] expo,
                                              input logic [31:0] n);
        logic [63:0] acc;
        logic [63:0] b;
        if (n == 32'd0)
            return 32'd0;
        b = 64'(base % n);
        acc = 64'(32'd1 % n);
        for (int i = 31; i >= 0; i--) begin
            acc = (acc * acc) % n;
            if (expo[i])
                acc = (acc * b) % n;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] predict_char_result(input logic op, input logic [31:0] value);
        logic [31:0] plain;
        logic [7:0]  ch;
        if (op == rcm_pkg::OP_ENCRYPT)
            return mod_power({24'd0, value[7:0]} + {24'd0, offset_q}, pub_exp_q, modulus_q);
        plain = mod_power(value, priv_exp_q, modulus_q);
        ch = plain[7:0] - offset_q;
        return {24'd0, ch};
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(4, 1);
        return $urandom_range(300, 20);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Result check first, then the new item, so a result can never match an item
    // accepted at the same edge.
    always @(posedge aclk) begin : result_monitor
        logic [31:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", m_result, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_result !== want)
                        report_mismatch("result", m_result, want);
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_char_result(s_operation, s_value));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: random stalls, plus a long hold-off when a test asks for one.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (sink_gap > 0) begin
                m_ready <= 1'b0;
                sink_gap = sink_gap - 1;
            end else begin
                m_ready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(input rcm_pkg::reg_idx_t idx, input logic [31:0] data);
        logic [31:0] want;
        want = (idx == rcm_pkg::REG_CHAR_OFFSET) ? {24'd0, data[7:0]} : data;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            rcm_pkg::REG_PUBLIC_EXP:  pub_exp_q  = data;
            rcm_pkg::REG_PRIVATE_EXP: priv_exp_q = data;
            rcm_pkg::REG_MODULUS:     modulus_q  = data;
            rcm_pkg::REG_CHAR_OFFSET: offset_q   = data[7:0];
        endcase
        // Read the register straight back.
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_key(input logic [31:0] e, input logic [31:0] d, input logic [31:0] n,
                            input logic [7:0] off);
        write_reg(rcm_pkg::REG_PUBLIC_EXP, e);
        write_reg(rcm_pkg::REG_PRIVATE_EXP, d);
        write_reg(rcm_pkg::REG_MODULUS, n);
        write_reg(rcm_pkg::REG_CHAR_OFFSET, {24'd0, off});
    endtask

    // Valid stays high after acceptance unless a gap follows.
    task automatic send_item(input logic op, input logic [31:0] value);
        int unsigned gap;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= value;
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_reset_values();
        // Wide character codes must be cut to their low byte, and decrypt bases
        // above the modulus reduced first.
        send_item(rcm_pkg::OP_ENCRYPT, 32'd0);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd255);
        send_item(rcm_pkg::OP_ENCRYPT, 32'hFFFF_FF41);
        send_item(rcm_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        send_item(rcm_pkg::OP_DECRYPT, 32'd99);
        send_item(rcm_pkg::OP_DECRYPT, 32'd0);
        wait_for_results();
    endtask

    task automatic test_corner_keys();
        // Zero exponents give 1 mod n for every base.
        load_key(32'd0, 32'd0, 32'd1000, 8'd255);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd255);
        send_item(rcm_pkg::OP_DECRYPT, 32'd12345);
        wait_for_results();
        // With a modulus of one every residue is zero.
        load_key(32'd65537, 32'd3, 32'd1, 8'd17);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd7);
        send_item(rcm_pkg::OP_DECRYPT, 32'd5);
        wait_for_results();
        // A zero modulus yields zero before the offset is removed.
        load_key(32'd5, 32'd7, 32'd0, 8'd200);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd65);
        send_item(rcm_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        wait_for_results();
        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd255);
        send_item(rcm_pkg::OP_DECRYPT, 32'hFFFF_FFFE);
        send_item(rcm_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        wait_for_results();
        load_key(32'd3, 32'd1, 32'd100, 8'd255);
        send_item(rcm_pkg::OP_ENCRYPT, 32'd255);
        send_item(rcm_pkg::OP_DECRYPT, 32'd1);
        wait_for_results();
    endtask

    task automatic test_roundtrip_key();
        logic [7:0]  ch;
        logic [31:0] cipher;
        load_key(32'd17, 32'd2753, 32'd3233, 8'd32);
        for (int i = 0; i < 20; i++) begin
            ch = 8'($urandom_range(223, 0));
            cipher = mod_power({24'd0, ch} + 32'd32, 32'd17, 32'd3233);
            send_item(rcm_pkg::OP_ENCRYPT, {24'd0, ch});
            send_item(rcm_pkg::OP_DECRYPT, cipher);
            if ($urandom_range(7, 0) == 0)
                send_item(rcm_pkg::OP_DECRYPT, $urandom);
        end
        wait_for_results();
    endtask

    task automatic test_random_keys();
        int unsigned roll;
        logic [31:0] n;
        logic        op;
        logic [31:0] value;
        for (int phase = 0; phase < 6; phase++) begin
            roll = $urandom_range(9, 0);
            if (roll < 6)
                n = $urandom;
            else if (roll < 9)
                n = $urandom_range(65535, 100);
            else
                n = $urandom_range(1, 0);
            load_key($urandom, $urandom, n, 8'($urandom_range(255, 0)));
            // One phase runs with no idling on either side.
            idle_on = (phase != 2);
            for (int i = 0; i < 35; i++) begin
                op = 1'($urandom_range(1, 0));
                if (op == rcm_pkg::OP_DECRYPT && modulus_q != 0 && $urandom_range(3, 0) != 0)
                    value = $urandom_range(modulus_q - 1, 0);
                else
                    value = $urandom;
                send_item(op, value);
            end
            wait_for_results();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_result_backpressure();
        load_key(32'h0001_0001, 32'hDEAD_BEEF, 32'hC000_0001, 8'd77);
        // The sink holds off long enough for the block to fill and stall its input.
        @(posedge aclk);
        sink_hold = LONG_HOLDOFF;
        idle_on = 1'b0;
        for (int i = 0; i < 6; i++)
            send_item(1'($urandom_range(1, 0)), $urandom);
        idle_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++)
            send_item(1'($urandom_range(1, 0)), $urandom);
        wait_for_results();
        for (int i = 0; i < 3; i++)
            send_item(1'($urandom_range(1, 0)), $urandom);
        wait_for_results();
    endtask

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'd0;
        pwdata      = 32'd0;
        s_valid     = 1'b0;
        s_operation = rcm_pkg::OP_ENCRYPT;
        s_value     = 32'd0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_corner_keys();
        test_roundtrip_key();
        test_random_keys();
        test_result_backpressure();
        test_sender_pause();

        wait_for_results();
        repeat (ITEM_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
